@@ src/rfpm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the rational function pixel map.
// Used by every module of the block; depends on nothing else.
package rfpm_pkg;

  localparam int unsigned MaxZerosDefault = 10;
  localparam int unsigned FracBitsDefault = 16;
  localparam longint      InvalidCoord    = -1000;
  localparam int unsigned SlotW           = 4;
  localparam int unsigned CountW          = 4;
  localparam int unsigned CfgIndexW       = 3;
  localparam int unsigned QuotBits        = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_AMP_REAL  = 3'd0,
    CFG_AMP_IMAG  = 3'd1,
    CFG_NUM_COUNT = 3'd2,
    CFG_DEN_COUNT = 3'd3
  } cfg_reg_e;

  // Input word.
  typedef struct packed {
    logic                mode;
    logic signed [31:0]  x_in;
    logic signed [31:0]  y_in;
    logic                invalid_in;
    logic                parity_in;
    logic                zero_table;
    logic [SlotW-1:0]    zero_slot;
    logic signed [31:0]  zero_real;
    logic signed [31:0]  zero_imag;
  } rfpm_in_t;

  // Output word.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               out_parity;
    logic               out_invalid;
    logic               out_overflow;
  } rfpm_out_t;

  // Word travelling through the zero stages.
  typedef struct packed {
    logic               load;
    logic               ztab;
    logic [SlotW-1:0]   slot;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] wr;
    logic signed [31:0] wi;
    logic signed [31:0] qr;
    logic signed [31:0] qi;
    logic               invalid;
    logic               parity;
    logic               ovf;
  } rfpm_item_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic                neg;
    logic                big;
    logic [63:0]         rem;
    logic [31:0]         lo;
    logic [QuotBits-1:0] quo;
  } rfpm_lane_t;

  // Word travelling through the divider.
  typedef struct packed {
    logic        invalid;
    logic        parity;
    logic        ovf;
    logic        dzero;
    logic [63:0] den;
    rfpm_lane_t  lx;
    rfpm_lane_t  ly;
  } rfpm_div_t;

  // Saturate a wide signed value to 32 bits; the top bit flags saturation.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // One restoring division step on a lane.
  function automatic rfpm_lane_t div_step(input rfpm_lane_t l, input logic [63:0] den);
    rfpm_lane_t  r;
    logic [64:0] part;
    logic        ge;
    r    = l;
    part = {l.rem, l.lo[31]};
    ge   = (part >= {1'b0, den});
    if (ge) begin
      part = part - {1'b0, den};
    end
    r.rem = part[63:0];
    r.lo  = {l.lo[30:0], 1'b0};
    r.quo = {l.quo[QuotBits-2:0], ge};
    return r;
  endfunction

  // Signed, saturated result of a finished lane; the top bit flags saturation.
  function automatic logic [32:0] lane_result(input rfpm_lane_t l);
    logic [32:0] r;
    if (l.neg) begin
      if (l.big || (l.quo > 32'h8000_0000)) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - l.quo};
      end
    end else begin
      if (l.big || l.quo[31]) begin
        r = {1'b1, 32'h7fff_ffff};
      end else begin
        r = {1'b0, l.quo};
      end
    end
    return r;
  endfunction

endpackage

@@ src/rfpm_zero_stage.sv @@
`timescale 1ns / 1ps
// One zero of the factored products: difference, complex multiply and rescale.
// Holds its own numerator and denominator zero; depends on rfpm_pkg.
module rfpm_zero_stage #(
  parameter int unsigned Index    = 0,
  parameter int unsigned FracBits = rfpm_pkg::FracBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  rfpm_pkg::rfpm_item_t          item_i,
  input  logic [rfpm_pkg::CountW-1:0]   num_count_i,
  input  logic [rfpm_pkg::CountW-1:0]   den_count_i,
  output logic                          valid_o,
  output rfpm_pkg::rfpm_item_t          item_o
);
  import rfpm_pkg::*;

  logic signed [31:0] nzr_q, nzi_q, dzr_q, dzi_q;

  logic               v1_q, v2_q, v3_q;
  rfpm_item_t         it1_q, it2_q, it3_q;
  logic [1:0]         act1_q, act2_q;
  logic signed [31:0] dnr_q, dni_q, ddr_q, ddi_q;
  logic signed [63:0] p_q [8];

  logic [1:0]         act_d;
  logic [32:0]        snr, sni, sdr, sdi;
  rfpm_item_t         it1_d, it3_d;
  logic signed [63:0] p_d [8];
  logic signed [65:0] sum_nr, sum_ni, sum_dr, sum_di;
  logic [32:0]        rnr, rni, rdr, rdi;
  logic               hit;

  // Load words write this stage's zero as they pass, keeping order with pixels.
  assign hit = en_i && valid_i && item_i.load && (item_i.slot == SlotW'(Index));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nzr_q <= '0;
      nzi_q <= '0;
      dzr_q <= '0;
      dzi_q <= '0;
    end else if (hit) begin
      if (item_i.ztab) begin
        dzr_q <= item_i.zr;
        dzi_q <= item_i.zi;
      end else begin
        nzr_q <= item_i.zr;
        nzi_q <= item_i.zi;
      end
    end
  end

  // First step: saturated differences to the zeros.
  always_comb begin
    act_d[0] = (num_count_i > CountW'(Index));
    act_d[1] = (den_count_i > CountW'(Index));
    snr = sat32(66'(item_i.x) - 66'(nzr_q));
    sni = sat32(66'(item_i.y) - 66'(nzi_q));
    sdr = sat32(66'(item_i.x) - 66'(dzr_q));
    sdi = sat32(66'(item_i.y) - 66'(dzi_q));
    it1_d = item_i;
    it1_d.ovf = item_i.ovf | (act_d[0] & (snr[32] | sni[32]))
                           | (act_d[1] & (sdr[32] | sdi[32]));
  end

  // Second step: the eight partial products.
  always_comb begin
    p_d[0] = it1_q.wr * dnr_q;
    p_d[1] = it1_q.wi * dni_q;
    p_d[2] = it1_q.wr * dni_q;
    p_d[3] = it1_q.wi * dnr_q;
    p_d[4] = it1_q.qr * ddr_q;
    p_d[5] = it1_q.qi * ddi_q;
    p_d[6] = it1_q.qr * ddi_q;
    p_d[7] = it1_q.qi * ddr_q;
  end

  // Third step: exact sums, floor rescale and saturation.
  always_comb begin
    sum_nr = (66'(p_q[0]) - 66'(p_q[1])) >>> FracBits;
    sum_ni = (66'(p_q[2]) + 66'(p_q[3])) >>> FracBits;
    sum_dr = (66'(p_q[4]) - 66'(p_q[5])) >>> FracBits;
    sum_di = (66'(p_q[6]) + 66'(p_q[7])) >>> FracBits;
    rnr = sat32(sum_nr);
    rni = sat32(sum_ni);
    rdr = sat32(sum_dr);
    rdi = sat32(sum_di);
    it3_d = it2_q;
    if (act2_q[0]) begin
      it3_d.wr  = rnr[31:0];
      it3_d.wi  = rni[31:0];
      it3_d.ovf = it3_d.ovf | rnr[32] | rni[32];
    end
    if (act2_q[1]) begin
      it3_d.qr  = rdr[31:0];
      it3_d.qi  = rdi[31:0];
      it3_d.ovf = it3_d.ovf | rdr[32] | rdi[32];
    end
  end

  // Valid bits of the three registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= it1_d;
      act1_q <= act_d;
      dnr_q  <= snr[31:0];
      dni_q  <= sni[31:0];
      ddr_q  <= sdr[31:0];
      ddi_q  <= sdi[31:0];
      it2_q  <= it1_q;
      act2_q <= act1_q;
      for (int i = 0; i < 8; i++) begin
        p_q[i] <= p_d[i];
      end
      it3_q  <= it3_d;
    end
  end

  assign valid_o = v3_q;
  assign item_o  = it3_q;

endmodule

@@ src/rfpm_div_prep.sv @@
`timescale 1ns / 1ps
// Forms w * conj(q) and |q|^2 and sets up both divider lanes.
// Three register stages; depends on rfpm_pkg.
module rfpm_div_prep #(
  parameter int unsigned FracBits = rfpm_pkg::FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rfpm_pkg::rfpm_item_t item_i,
  output logic                 valid_o,
  output rfpm_pkg::rfpm_div_t  div_o
);
  import rfpm_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic [2:0]         fl1_q, fl2_q;
  logic signed [63:0] p_q [6];
  logic signed [63:0] p_d [6];
  logic               negx_q, negy_q, dz_q;
  logic [63:0]        magx_q, magy_q, den_q;
  rfpm_div_t          div_q;

  logic signed [64:0] nre, nim;
  logic [63:0]        den_d;
  logic [95:0]        lhsx, lhsy, rhs;
  rfpm_div_t          div_d;

  // Products of w with q, and of q with itself.
  always_comb begin
    p_d[0] = item_i.wr * item_i.qr;
    p_d[1] = item_i.wi * item_i.qi;
    p_d[2] = item_i.wi * item_i.qr;
    p_d[3] = item_i.wr * item_i.qi;
    p_d[4] = item_i.qr * item_i.qr;
    p_d[5] = item_i.qi * item_i.qi;
  end

  // Exact numerators and the squared modulus.
  always_comb begin
    nre   = 65'(p_q[0]) + 65'(p_q[1]);
    nim   = 65'(p_q[2]) - 65'(p_q[3]);
    den_d = 64'(p_q[4]) + 64'(p_q[5]);
  end

  // Scale the magnitudes and check whether the quotient exceeds 32 bits.
  always_comb begin
    lhsx = {32'd0, magx_q} << FracBits;
    lhsy = {32'd0, magy_q} << FracBits;
    rhs  = {den_q, 32'd0};
    div_d.invalid = fl2_q[2];
    div_d.parity  = fl2_q[1];
    div_d.ovf     = fl2_q[0];
    div_d.dzero   = dz_q;
    div_d.den     = den_q;
    div_d.lx.neg  = negx_q;
    div_d.lx.big  = (lhsx >= rhs);
    div_d.lx.rem  = lhsx[95:32];
    div_d.lx.lo   = lhsx[31:0];
    div_d.lx.quo  = '0;
    div_d.ly.neg  = negy_q;
    div_d.ly.big  = (lhsy >= rhs);
    div_d.ly.rem  = lhsy[95:32];
    div_d.ly.lo   = lhsy[31:0];
    div_d.ly.quo  = '0;
  end

  // Load words end here: they produce no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i && !item_i.load;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl1_q <= {item_i.invalid, item_i.parity, item_i.ovf};
      for (int i = 0; i < 6; i++) begin
        p_q[i] <= p_d[i];
      end
      fl2_q  <= fl1_q;
      negx_q <= nre[64];
      magx_q <= nre[64] ? 64'(-nre) : 64'(nre);
      negy_q <= nim[64];
      magy_q <= nim[64] ? 64'(-nim) : 64'(nim);
      den_q  <= den_d;
      dz_q   <= (den_d == 64'd0);
      div_q  <= div_d;
    end
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;

endmodule

@@ src/rfpm_div_stage.sv @@
`timescale 1ns / 1ps
// One quotient bit of the restoring divider, for both the real and imaginary lanes.
// Depends on rfpm_pkg.
module rfpm_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rfpm_pkg::rfpm_div_t div_i,
  output logic                valid_o,
  output rfpm_pkg::rfpm_div_t div_o
);
  import rfpm_pkg::*;

  logic      v_q;
  rfpm_div_t div_q, div_d;

  // Compare, subtract and shift in the next dividend bit.
  always_comb begin
    div_d    = div_i;
    div_d.lx = div_step(div_i.lx, div_i.den);
    div_d.ly = div_step(div_i.ly, div_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = v_q;
  assign div_o   = div_q;

endmodule

@@ src/rational_function_pixel_map_core.sv @@
`timescale 1ns / 1ps
// Top level of the rational function pixel map: configuration, pipeline and output.
// Depends on rfpm_pkg, rfpm_zero_stage, rfpm_div_prep and rfpm_div_stage.
//
// Maps each pixel z = x + iy, in signed fixed point with FracBits fraction bits, to
// w = A * prod(z - a_k) / prod(z - b_k) and flags saturation or a zero denominator.
// A word with mode set loads one zero into the numerator or denominator table; it
// yields no output word, and pixels behind it see the new zero. The block takes one
// word every cycle while no output word is held by stall, and a pixel's result passes
// through three stages per zero slot, three to form the division, one stage per
// quotient bit of the 32-bit restoring divider and one output register. The whole
// pipeline halts while an output word is held by stall, so in_stall_o is high then.
// Configuration is taken at once (cfg_ready_o is always high) and is meant to be
// written only while no pixel is in flight.
module rational_function_pixel_map_core #(
  parameter int unsigned MaxZeros = rfpm_pkg::MaxZerosDefault,
  parameter int unsigned FracBits = rfpm_pkg::FracBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rfpm_pkg::rfpm_in_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rfpm_pkg::rfpm_out_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rfpm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import rfpm_pkg::*;

  localparam logic [31:0] OneFix  = 32'd1 << FracBits;
  localparam longint      InvFull = InvalidCoord * (longint'(1) << FracBits);
  localparam logic [31:0] InvFix  = (InvFull < -64'sd2147483648) ? 32'h8000_0000
                                                                   : 32'(InvFull);

  logic signed [31:0]  amp_real_q, amp_imag_q;
  logic [CountW-1:0]   num_count_q, den_count_q;
  logic                en;
  rfpm_item_t          entry;
  rfpm_item_t          chain [MaxZeros+1];
  logic [MaxZeros:0]   chain_v;
  rfpm_div_t           dw [QuotBits+1];
  logic [QuotBits:0]   dv;
  logic                out_valid_q;
  rfpm_out_t           out_q, out_d;
  logic [32:0]         rx, ry;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_real_q  <= OneFix;
      amp_imag_q  <= '0;
      num_count_q <= '0;
      den_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_AMP_REAL:  amp_real_q  <= cfg_data_i;
        CFG_AMP_IMAG:  amp_imag_q  <= cfg_data_i;
        CFG_NUM_COUNT: num_count_q <= cfg_data_i[CountW-1:0];
        CFG_DEN_COUNT: den_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unless the output word is held.
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Entry word: products start at A and at one.
  always_comb begin
    entry.load    = in_word_i.mode;
    entry.ztab    = in_word_i.zero_table;
    entry.slot    = in_word_i.zero_slot;
    entry.zr      = in_word_i.zero_real;
    entry.zi      = in_word_i.zero_imag;
    entry.x       = in_word_i.x_in;
    entry.y       = in_word_i.y_in;
    entry.wr      = amp_real_q;
    entry.wi      = amp_imag_q;
    entry.qr      = OneFix;
    entry.qi      = '0;
    entry.invalid = in_word_i.invalid_in;
    entry.parity  = in_word_i.parity_in;
    entry.ovf     = 1'b0;
  end

  assign chain[0]   = entry;
  assign chain_v[0] = in_valid_i;

  // Zero slots, highest index first.
  for (genvar j = 0; j < MaxZeros; j++) begin : g_zero
    rfpm_zero_stage #(
      .Index    (MaxZeros - 1 - j),
      .FracBits (FracBits)
    ) u_zero (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .valid_i     (chain_v[j]),
      .item_i      (chain[j]),
      .num_count_i (num_count_q),
      .den_count_i (den_count_q),
      .valid_o     (chain_v[j+1]),
      .item_o      (chain[j+1])
    );
  end

  rfpm_div_prep #(
    .FracBits (FracBits)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_v[MaxZeros]),
    .item_i  (chain[MaxZeros]),
    .valid_o (dv[0]),
    .div_o   (dw[0])
  );

  // One quotient bit per stage.
  for (genvar b = 0; b < QuotBits; b++) begin : g_div
    rfpm_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[b]),
      .div_i   (dw[b]),
      .valid_o (dv[b+1]),
      .div_o   (dw[b+1])
    );
  end

  // Sign, saturation and the special cases.
  always_comb begin
    rx = lane_result(dw[QuotBits].lx);
    ry = lane_result(dw[QuotBits].ly);
    if (dw[QuotBits].invalid) begin
      out_d.out_x        = InvFix;
      out_d.out_y        = InvFix;
      out_d.out_parity   = 1'b0;
      out_d.out_invalid  = 1'b1;
      out_d.out_overflow = 1'b0;
    end else if (dw[QuotBits].dzero) begin
      out_d.out_x        = '0;
      out_d.out_y        = '0;
      out_d.out_parity   = dw[QuotBits].parity;
      out_d.out_invalid  = 1'b0;
      out_d.out_overflow = 1'b1;
    end else begin
      out_d.out_x        = rx[31:0];
      out_d.out_y        = ry[31:0];
      out_d.out_parity   = dw[QuotBits].parity;
      out_d.out_invalid  = 1'b0;
      out_d.out_overflow = dw[QuotBits].ovf | rx[32] | ry[32];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // An invalid pixel always gives the fixed marker word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.out_invalid |->
      out_word_o.out_x == InvFix && out_word_o.out_y == InvFix &&
      !out_word_o.out_overflow && !out_word_o.out_parity)
    else $error("invalid pixel word malformed");

  // While the pipeline is halted no internal valid bit moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain_v[MaxZeros:1]) && $stable(dv))
    else $error("pipeline moved while halted");

  // A zero denominator reaching the end raises the overflow flag with a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv[QuotBits] && dw[QuotBits].dzero && !dw[QuotBits].invalid |=>
      out_valid_o && out_word_o.out_overflow && out_word_o.out_x == '0 &&
      out_word_o.out_y == '0)
    else $error("zero denominator not flagged");

endmodule
